// File: design/ray_box_slab_intersection_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef RAY_BOX_SLAB_INTERSECTION_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECTION_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define RBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbs assertion failed");

// Next-cycle implication, off while reset is high.
`define RBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbs assertion failed");

// Next-cycle implication that is also checked across reset.
`define RBS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rbs assertion failed");

`endif

// File: design/rbs_pkg.sv
`default_nettype none
package rbs_pkg;

  localparam int FRAC_BITS = 32;
  localparam int DATA_W = 64;
  localparam logic [DATA_W-1:0] EPS_LSB =
    DATA_W'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam int NUM_AXES = 3;

  // Divider: quotient bits resolved per pipeline stage.
  localparam int DIV_BITS = 4;
  localparam int DIV_ITER = DATA_W / DIV_BITS;
  // One setup stage, the iteration stages, one saturation stage.
  localparam int DIV_STAGES = DIV_ITER + 2;
  // Operand stage, divider, two merge stages.
  localparam int PIPE_STAGES = DIV_STAGES + 3;

  localparam int CFG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] origin_x;
    logic signed [DATA_W-1:0] origin_y;
    logic signed [DATA_W-1:0] origin_z;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] dir_z;
    logic signed [DATA_W-1:0] t_min;
    logic signed [DATA_W-1:0] t_max;
  } ray_in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] entry_t;
  } ray_out_t;

  // Per-ray flags and window that travel beside the dividers.
  typedef struct packed {
    logic [NUM_AXES-1:0]      par;
    logic [NUM_AXES-1:0]      pmiss;
    logic [NUM_AXES-1:0]      dneg;
    logic signed [DATA_W-1:0] t_min;
    logic signed [DATA_W-1:0] t_max;
  } side_t;

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] sh;
    logic [DATA_W-1:0] q;
  } div_st_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] t0;
    logic signed [DATA_W-1:0] t1;
    logic                     alive;
  } slab_t;

  // One restoring division step: bring in the next dividend bit.
  function automatic div_st_t div_step(div_st_t s, logic [DATA_W-1:0] dm);
    div_st_t r;
    logic [DATA_W:0] trial;
    trial = {s.rem, s.sh[DATA_W-1]};
    r.sh = s.sh << 1;
    r.q = s.q << 1;
    if (trial >= {1'b0, dm}) begin
      trial = trial - {1'b0, dm};
      r.q[0] = 1'b1;
    end
    r.rem = trial[DATA_W-1:0];
    return r;
  endfunction

  // Narrow the interval by one axis, then check that it is still open.
  function automatic slab_t slab_axis(slab_t s, logic par, logic pmiss, logic dneg,
                                      logic signed [DATA_W-1:0] qa,
                                      logic signed [DATA_W-1:0] qb);
    slab_t r;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W:0] t0e;
    logic signed [DATA_W:0] t1e;
    r = s;
    a = dneg ? qb : qa;
    b = dneg ? qa : qb;
    if (par) begin
      if (pmiss) begin
        r.alive = 1'b0;
      end
    end else begin
      if (a > r.t0) begin
        r.t0 = a;
      end
      if (b < r.t1) begin
        r.t1 = b;
      end
    end
    t0e = {r.t0[DATA_W-1], r.t0} + $signed({1'b0, EPS_LSB});
    t1e = {r.t1[DATA_W-1], r.t1};
    if (!(t1e > t0e)) begin
      r.alive = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/rbs_div_lane.sv
`default_nettype none
module rbs_div_lane (
  input  logic                                clk,
  input  logic [rbs_pkg::DIV_STAGES-1:0]      en,
  input  logic [rbs_pkg::DATA_W-1:0]          n,
  input  logic [rbs_pkg::DATA_W-1:0]          dm,
  input  logic                                neg,
  output logic signed [rbs_pkg::DATA_W-1:0]   q
);

  rbs_pkg::div_st_t st [rbs_pkg::DIV_ITER+1];
  logic [rbs_pkg::DATA_W-1:0] dmr [rbs_pkg::DIV_ITER];
  logic negr [rbs_pkg::DIV_ITER+1];
  logic ovf [rbs_pkg::DIV_ITER+1];
  logic [rbs_pkg::DATA_W-1:0] top_bits;
  logic ovf0;
  logic [rbs_pkg::DATA_W-1:0] qf;

  // Quotient reaches 2^64 exactly when the upper dividend part is not below the divisor.
  assign top_bits = n >> (rbs_pkg::DATA_W - rbs_pkg::FRAC_BITS);
  assign ovf0 = top_bits >= dm;

  // Setup stage.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0].rem <= ovf0 ? '0 : top_bits;
      st[0].sh  <= n << rbs_pkg::FRAC_BITS;
      st[0].q   <= '0;
      dmr[0]    <= dm;
      negr[0]   <= neg;
      ovf[0]    <= ovf0;
    end
  end

  // Iteration stages, a few quotient bits each.
  for (genvar s = 1; s <= rbs_pkg::DIV_ITER; s++) begin : g_iter
    rbs_pkg::div_st_t nxt;

    always_comb begin
      nxt = st[s-1];
      for (int k = 0; k < rbs_pkg::DIV_BITS; k++) begin
        nxt = rbs_pkg::div_step(nxt, dmr[s-1]);
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st[s]   <= nxt;
        negr[s] <= negr[s-1];
        ovf[s]  <= ovf[s-1];
      end
    end

    if (s < rbs_pkg::DIV_ITER) begin : g_dm
      always_ff @(posedge clk) begin
        if (en[s]) begin
          dmr[s] <= dmr[s-1];
        end
      end
    end
  end

  // Sign and saturation stage.
  assign qf = st[rbs_pkg::DIV_ITER].q;

  always_ff @(posedge clk) begin
    if (en[rbs_pkg::DIV_ITER+1]) begin
      if (!negr[rbs_pkg::DIV_ITER]) begin
        q <= (ovf[rbs_pkg::DIV_ITER] || qf[rbs_pkg::DATA_W-1]) ? rbs_pkg::S_MAX
                                                               : $signed(qf);
      end else begin
        q <= (ovf[rbs_pkg::DIV_ITER] || qf > rbs_pkg::NEG_LIMIT) ? rbs_pkg::S_MIN
                                                                 : $signed(~qf + 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/rbs_slab_merge.sv
`default_nettype none
module rbs_slab_merge (
  input  logic                                                    clk,
  input  logic [1:0]                                              en,
  input  rbs_pkg::side_t                                          side,
  input  logic [rbs_pkg::NUM_AXES-1:0][rbs_pkg::DATA_W-1:0]       q_lo,
  input  logic [rbs_pkg::NUM_AXES-1:0][rbs_pkg::DATA_W-1:0]       q_hi,
  output rbs_pkg::ray_out_t                                       out_data
);

  rbs_pkg::slab_t s_in;
  rbs_pkg::slab_t s_x;
  rbs_pkg::slab_t s_xy;
  rbs_pkg::slab_t s1;
  rbs_pkg::slab_t s_z;
  rbs_pkg::side_t side1;
  logic [rbs_pkg::DATA_W-1:0] qz_lo;
  logic [rbs_pkg::DATA_W-1:0] qz_hi;
  logic hit;

  // First stage: start from the window and apply the x and y slabs.
  always_comb begin
    s_in.t0 = side.t_min;
    s_in.t1 = side.t_max;
    s_in.alive = 1'b1;
    s_x = rbs_pkg::slab_axis(s_in, side.par[0], side.pmiss[0], side.dneg[0],
                             $signed(q_lo[0]), $signed(q_hi[0]));
    s_xy = rbs_pkg::slab_axis(s_x, side.par[1], side.pmiss[1], side.dneg[1],
                              $signed(q_lo[1]), $signed(q_hi[1]));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1    <= s_xy;
      side1 <= side;
      qz_lo <= q_lo[2];
      qz_hi <= q_hi[2];
    end
  end

  // Second stage: z slab and the final window check.
  always_comb begin
    s_z = rbs_pkg::slab_axis(s1, side1.par[2], side1.pmiss[2], side1.dneg[2],
                             $signed(qz_lo), $signed(qz_hi));
    hit = s_z.alive && (s_z.t0 >= side1.t_min) && (s_z.t0 <= side1.t_max);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      out_data.hit     <= hit;
      out_data.entry_t <= hit ? s_z.t0 : '0;
    end
  end

endmodule
`default_nettype wire

// File: design/ray_box_slab_intersection.sv
// Ray versus axis-aligned box test by the slab method, one ray per transaction.
// Input channel in_valid/in_ready carries in_data (origin, direction, window).
// Output channel out_valid/out_ready carries out_data (hit, entry_t); every
// input transaction yields exactly one output transaction, in order.
// Box corners are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// Throughput: one ray per cycle while out_ready is high, set by a 21-stage
// pipeline whose dividers resolve four quotient bits per stage.
// Each stage holds its item when the stage after it is full and stalled, so
// a stalled receiver first lets bubbles close up; in_ready drops only when
// every stage is full and out_ready is low. Nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears the box corners to zero.
`default_nettype none
module ray_box_slab_intersection (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rbs_pkg::ray_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rbs_pkg::ray_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbs_pkg::DATA_W-1:0]          cfg_data
);

  logic signed [rbs_pkg::DATA_W-1:0] box_min [rbs_pkg::NUM_AXES];
  logic signed [rbs_pkg::DATA_W-1:0] box_max [rbs_pkg::NUM_AXES];

  logic [rbs_pkg::PIPE_STAGES-1:0] v;
  logic [rbs_pkg::PIPE_STAGES-1:0] en;

  logic signed [rbs_pkg::DATA_W-1:0] o_ax [rbs_pkg::NUM_AXES];
  logic signed [rbs_pkg::DATA_W-1:0] d_ax [rbs_pkg::NUM_AXES];

  logic [rbs_pkg::NUM_AXES-1:0][rbs_pkg::DATA_W-1:0] n_lo_p;
  logic [rbs_pkg::NUM_AXES-1:0][rbs_pkg::DATA_W-1:0] n_hi_p;
  logic [rbs_pkg::NUM_AXES-1:0][rbs_pkg::DATA_W-1:0] dm_p;
  logic [rbs_pkg::NUM_AXES-1:0] neg_lo_p;
  logic [rbs_pkg::NUM_AXES-1:0] neg_hi_p;
  rbs_pkg::side_t side_p;
  rbs_pkg::side_t side_d [rbs_pkg::DIV_STAGES];

  logic [rbs_pkg::NUM_AXES-1:0][rbs_pkg::DATA_W-1:0] q_lo;
  logic [rbs_pkg::NUM_AXES-1:0][rbs_pkg::DATA_W-1:0] q_hi;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rbs_pkg::NUM_AXES; i++) begin
        box_min[i] <= '0;
        box_max[i] <= '0;
      end
    end else if (cfg_we) begin
      case (rbs_pkg::cfg_reg_t'(cfg_index))
        rbs_pkg::CFG_BOX_MIN_X: box_min[0] <= cfg_data;
        rbs_pkg::CFG_BOX_MIN_Y: box_min[1] <= cfg_data;
        rbs_pkg::CFG_BOX_MIN_Z: box_min[2] <= cfg_data;
        rbs_pkg::CFG_BOX_MAX_X: box_max[0] <= cfg_data;
        rbs_pkg::CFG_BOX_MAX_Y: box_max[1] <= cfg_data;
        rbs_pkg::CFG_BOX_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor moves.
  assign en[rbs_pkg::PIPE_STAGES-1] = !v[rbs_pkg::PIPE_STAGES-1] || out_ready;
  for (genvar i = 0; i < rbs_pkg::PIPE_STAGES - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  assign in_ready = en[0];
  assign out_valid = v[rbs_pkg::PIPE_STAGES-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (en & {v[rbs_pkg::PIPE_STAGES-2:0], in_valid}) | (~en & v);
    end
  end

  assign o_ax[0] = in_data.origin_x;
  assign o_ax[1] = in_data.origin_y;
  assign o_ax[2] = in_data.origin_z;
  assign d_ax[0] = in_data.dir_x;
  assign d_ax[1] = in_data.dir_y;
  assign d_ax[2] = in_data.dir_z;

  // Operand stage: corner differences, divisor magnitude, parallel test.
  for (genvar a = 0; a < rbs_pkg::NUM_AXES; a++) begin : g_prep
    logic signed [rbs_pkg::DATA_W:0] oe;
    logic signed [rbs_pkg::DATA_W:0] le;
    logic signed [rbs_pkg::DATA_W:0] he;
    logic signed [rbs_pkg::DATA_W:0] eps_e;
    logic signed [rbs_pkg::DATA_W:0] dl;
    logic signed [rbs_pkg::DATA_W:0] dh;
    logic [rbs_pkg::DATA_W:0] dl_neg;
    logic [rbs_pkg::DATA_W:0] dh_neg;
    logic [rbs_pkg::DATA_W-1:0] dmag;
    logic pmiss;

    assign oe = {o_ax[a][rbs_pkg::DATA_W-1], o_ax[a]};
    assign le = {box_min[a][rbs_pkg::DATA_W-1], box_min[a]};
    assign he = {box_max[a][rbs_pkg::DATA_W-1], box_max[a]};
    assign eps_e = $signed({1'b0, rbs_pkg::EPS_LSB});
    assign dl = le - oe;
    assign dh = he - oe;
    assign dl_neg = -dl;
    assign dh_neg = -dh;
    assign dmag = d_ax[a][rbs_pkg::DATA_W-1] ? (~d_ax[a] + 1'b1) : d_ax[a];
    assign pmiss = (oe + eps_e < le) || (oe - eps_e > he);

    always_ff @(posedge clk) begin
      if (en[0]) begin
        n_lo_p[a]      <= dl[rbs_pkg::DATA_W] ? dl_neg[rbs_pkg::DATA_W-1:0]
                                              : dl[rbs_pkg::DATA_W-1:0];
        n_hi_p[a]      <= dh[rbs_pkg::DATA_W] ? dh_neg[rbs_pkg::DATA_W-1:0]
                                              : dh[rbs_pkg::DATA_W-1:0];
        neg_lo_p[a]    <= dl[rbs_pkg::DATA_W] ^ d_ax[a][rbs_pkg::DATA_W-1];
        neg_hi_p[a]    <= dh[rbs_pkg::DATA_W] ^ d_ax[a][rbs_pkg::DATA_W-1];
        dm_p[a]        <= dmag;
        side_p.par[a]  <= dmag <= rbs_pkg::EPS_LSB;
        side_p.pmiss[a] <= pmiss;
        side_p.dneg[a] <= d_ax[a][rbs_pkg::DATA_W-1];
      end
    end

    // Entry and exit distances for this axis.
    rbs_div_lane u_div_lo (
      .clk (clk),
      .en  (en[rbs_pkg::DIV_STAGES:1]),
      .n   (n_lo_p[a]),
      .dm  (dm_p[a]),
      .neg (neg_lo_p[a]),
      .q   (q_lo[a])
    );

    rbs_div_lane u_div_hi (
      .clk (clk),
      .en  (en[rbs_pkg::DIV_STAGES:1]),
      .n   (n_hi_p[a]),
      .dm  (dm_p[a]),
      .neg (neg_hi_p[a]),
      .q   (q_hi[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_p.t_min <= in_data.t_min;
      side_p.t_max <= in_data.t_max;
    end
  end

  // Flags and window ride beside the dividers.
  for (genvar s = 0; s < rbs_pkg::DIV_STAGES; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[s+1]) begin
        side_d[s] <= (s == 0) ? side_p : side_d[(s == 0) ? 0 : s-1];
      end
    end
  end

  rbs_slab_merge u_merge (
    .clk      (clk),
    .en       (en[rbs_pkg::PIPE_STAGES-1:rbs_pkg::PIPE_STAGES-2]),
    .side     (side_d[rbs_pkg::DIV_STAGES-1]),
    .q_lo     (q_lo),
    .q_hi     (q_hi),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// File: design/rbs_checker.sv
`default_nettype none
`include "ray_box_slab_intersection_assert.svh"
module rbs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input rbs_pkg::ray_out_t                   out_data
);

  // A result held back by the receiver stays put.
  `RBS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // A miss always reports a zero distance.
  `RBS_ASSERT_IMPL(a_miss_zero, clk, rst, out_valid && !out_data.hit, out_data.entry_t == '0)

  // Input is refused only when the output side is backed up.
  `RBS_ASSERT_IMPL(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready)

  // Reset leaves the pipeline empty.
  `RBS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind ray_box_slab_intersection rbs_checker u_rbs_checker (.*);
`default_nettype wire

// File: test/ray_box_slab_intersection_tb.sv
`timescale 1ns / 1ps
module ray_box_slab_intersection_tb;

  typedef logic signed [rbs_pkg::DATA_W-1:0] fix_t;
  typedef logic signed [rbs_pkg::DATA_W+1:0] wide_t;

  // Expected hit results and a private copy of the box corners.
  class slab_scoreboard;
    rbs_pkg::ray_out_t expected_hits[$];
    fix_t box_lo[rbs_pkg::NUM_AXES];
    fix_t box_hi[rbs_pkg::NUM_AXES];
    int errors;

    function new();
      errors = 0;
      foreach (box_lo[i]) begin
        box_lo[i] = '0;
        box_hi[i] = '0;
      end
    endfunction

    task report(string what, logic [rbs_pkg::DATA_W-1:0] got,
                logic [rbs_pkg::DATA_W-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    function wide_t widen(fix_t v);
      return {{2{v[rbs_pkg::DATA_W-1]}}, v};
    endfunction

    // Slab distance (c - o) / d in fixed point, truncated and saturated.
    function fix_t slab_distance(fix_t c, fix_t o, fix_t d);
      wide_t diff;
      wide_t mag;
      logic [127:0] num;
      logic [127:0] q;
      logic [rbs_pkg::DATA_W-1:0] dm;
      logic neg;
      diff = widen(c) - widen(o);
      neg = diff[rbs_pkg::DATA_W+1] ^ d[rbs_pkg::DATA_W-1];
      mag = diff[rbs_pkg::DATA_W+1] ? -diff : diff;
      num = 128'(mag[rbs_pkg::DATA_W-1:0]) << rbs_pkg::FRAC_BITS;
      dm = d[rbs_pkg::DATA_W-1] ? -d : d;
      q = num / {64'd0, dm};
      if (!neg) begin
        return (q > 128'(rbs_pkg::S_MAX)) ? rbs_pkg::S_MAX
                                          : fix_t'(q[rbs_pkg::DATA_W-1:0]);
      end
      return (q > (128'd1 << 63)) ? rbs_pkg::S_MIN : fix_t'(-q[rbs_pkg::DATA_W-1:0]);
    endfunction

    // Narrow the interval by one axis; returns 0 on a miss.
    function bit narrow_axis(fix_t lo, fix_t hi, fix_t o, fix_t d,
                             inout fix_t t0, inout fix_t t1);
      wide_t eps;
      logic [rbs_pkg::DATA_W-1:0] dm;
      fix_t a;
      fix_t b;
      fix_t tmp;
      eps = wide_t'({2'b00, rbs_pkg::EPS_LSB});
      dm = d[rbs_pkg::DATA_W-1] ? -d : d;
      if (dm <= rbs_pkg::EPS_LSB) begin
        // Ray runs along the slab: origin must lie inside it, widened by epsilon.
        if (widen(o) + eps < widen(lo) || widen(o) - eps > widen(hi)) begin
          return 1'b0;
        end
      end else begin
        a = slab_distance(lo, o, d);
        b = slab_distance(hi, o, d);
        if (d[rbs_pkg::DATA_W-1]) begin
          tmp = a;
          a = b;
          b = tmp;
        end
        if (a > t0) begin
          t0 = a;
        end
        if (b < t1) begin
          t1 = b;
        end
      end
      return widen(t1) > widen(t0) + eps;
    endfunction

    function void note_ray(rbs_pkg::ray_in_t r);
      fix_t t0;
      fix_t t1;
      fix_t org[rbs_pkg::NUM_AXES];
      fix_t dir[rbs_pkg::NUM_AXES];
      bit alive;
      rbs_pkg::ray_out_t res;
      org[0] = r.origin_x;
      org[1] = r.origin_y;
      org[2] = r.origin_z;
      dir[0] = r.dir_x;
      dir[1] = r.dir_y;
      dir[2] = r.dir_z;
      t0 = r.t_min;
      t1 = r.t_max;
      alive = 1'b1;
      for (int i = 0; i < rbs_pkg::NUM_AXES; i++) begin
        if (alive) begin
          alive = narrow_axis(box_lo[i], box_hi[i], org[i], dir[i], t0, t1);
        end
      end
      if (alive && (t0 < r.t_min || t0 > r.t_max)) begin
        alive = 1'b0;
      end
      res.hit = alive;
      res.entry_t = alive ? t0 : '0;
      expected_hits.push_back(res);
    endfunction

    task check_result(rbs_pkg::ray_out_t got);
      rbs_pkg::ray_out_t want;
      if (expected_hits.size() == 0) begin
        report("unexpected transaction", got.entry_t, '0);
      end else begin
        want = expected_hits.pop_front();
        if (got.hit !== want.hit) begin
          report("hit", 64'(got.hit), 64'(want.hit));
        end
        if (got.entry_t !== want.entry_t) begin
          report("entry_t", got.entry_t, want.entry_t);
        end
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  rbs_pkg::ray_in_t in_data;
  logic out_valid;
  logic out_ready;
  rbs_pkg::ray_out_t out_data;
  logic cfg_we;
  logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rbs_pkg::DATA_W-1:0] cfg_data;

  slab_scoreboard sb;
  bit quiet;
  bit calm;
  int stall_left;

  ray_box_slab_intersection uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #20ms;
    $display("ray_box_slab_intersection regression: fail");
    $finish;
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // Receiver stalls in random bursts.
  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 13);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function logic [rbs_pkg::DATA_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Random value within +/- 2^bits.
  function fix_t rnd_span(int bits);
    return fix_t'(rnd64()) >>> (rbs_pkg::DATA_W - 1 - bits);
  endfunction

  // Corner values of a field, or full random.
  function fix_t odd_val();
    case ($urandom_range(0, 9))
      0: return rbs_pkg::S_MIN;
      1: return rbs_pkg::S_MAX;
      2: return '0;
      3: return fix_t'(1);
      4: return -fix_t'(1);
      5: return fix_t'(rbs_pkg::EPS_LSB);
      6: return -fix_t'(rbs_pkg::EPS_LSB);
      7: return fix_t'(rbs_pkg::EPS_LSB) + fix_t'($urandom_range(0, 2)) - 1;
      default: return fix_t'(rnd64());
    endcase
  endfunction

  task send_ray(rbs_pkg::ray_in_t r);
    if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_ray(r);
  endtask

  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Box corners are written only once the pipeline is empty.
  task set_box(fix_t lx, fix_t ly, fix_t lz, fix_t hx, fix_t hy, fix_t hz);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= rbs_pkg::CFG_BOX_MIN_X; cfg_data <= lx;
    @(negedge clk);
    cfg_index <= rbs_pkg::CFG_BOX_MIN_Y; cfg_data <= ly;
    @(negedge clk);
    cfg_index <= rbs_pkg::CFG_BOX_MIN_Z; cfg_data <= lz;
    @(negedge clk);
    cfg_index <= rbs_pkg::CFG_BOX_MAX_X; cfg_data <= hx;
    @(negedge clk);
    cfg_index <= rbs_pkg::CFG_BOX_MAX_Y; cfg_data <= hy;
    @(negedge clk);
    cfg_index <= rbs_pkg::CFG_BOX_MAX_Z; cfg_data <= hz;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.box_lo[0] = lx; sb.box_lo[1] = ly; sb.box_lo[2] = lz;
    sb.box_hi[0] = hx; sb.box_hi[1] = hy; sb.box_hi[2] = hz;
  endtask

  function rbs_pkg::ray_in_t make_ray(fix_t ox, fix_t oy, fix_t oz, fix_t dx, fix_t dy,
                                      fix_t dz, fix_t tlo, fix_t thi);
    rbs_pkg::ray_in_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.t_min = tlo; r.t_max = thi;
    return r;
  endfunction

  // Ray aimed at a point near the box, with some variations.
  function rbs_pkg::ray_in_t random_ray();
    rbs_pkg::ray_in_t r;
    fix_t org[rbs_pkg::NUM_AXES];
    fix_t dir[rbs_pkg::NUM_AXES];
    fix_t target;
    fix_t span;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind >= 80) begin
      return make_ray(odd_val(), odd_val(), odd_val(), odd_val(), odd_val(), odd_val(),
                      odd_val(), odd_val());
    end
    for (int i = 0; i < rbs_pkg::NUM_AXES; i++) begin
      span = sb.box_hi[i] - sb.box_lo[i];
      if (span > 0 && span < (fix_t'(1) <<< 44)) begin
        target = sb.box_lo[i] + fix_t'(rnd64() % 64'(span + 1));
      end else begin
        target = rnd_span(40);
      end
      org[i] = rnd_span(42);
      dir[i] = (target - org[i]) >>> $urandom_range(0, 8);
      if (kind >= 65 && $urandom_range(0, 2) == 0) begin
        dir[i] = fix_t'($urandom_range(0, 2 * rbs_pkg::EPS_LSB + 4))
                 - fix_t'(rbs_pkg::EPS_LSB) - 2;
      end
    end
    r = make_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2], '0, rbs_pkg::S_MAX);
    if ($urandom_range(0, 3) == 0) begin
      r.t_min = rnd_span(36);
      r.t_max = r.t_min + fix_t'(rnd64() >> 24);
    end
    return r;
  endfunction

  task random_rays(int n);
    for (int k = 0; k < n; k++) begin
      calm = ((k / 50) % 3) == 2;
      send_ray(random_ray());
    end
  endtask

  initial begin
    fix_t one;
    fix_t eps;
    fix_t smin;
    fix_t smax;
    sb = new();
    one = fix_t'(1) <<< rbs_pkg::FRAC_BITS;
    eps = fix_t'(rbs_pkg::EPS_LSB);
    smin = rbs_pkg::S_MIN;
    smax = rbs_pkg::S_MAX;
    quiet = 1'b0;
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = rbs_pkg::CFG_BOX_MIN_X;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Degenerate box at reset: all corners zero.
    random_rays(60);

    // Unit box, directed cases.
    set_box(-one, -one, -one, one, one, one);
    send_ray(make_ray(-5 * one, 0, 0, one, 0, 0, 0, smax));
    send_ray(make_ray(5 * one, one / 2, 0, -one, 0, 0, 0, smax));
    send_ray(make_ray(0, 0, 0, one, one, one, smin, smax));
    send_ray(make_ray(-5 * one, 2 * one, 0, one, 0, 0, 0, smax));
    send_ray(make_ray(-5 * one, one + eps, 0, one, eps, 0, 0, smax));
    send_ray(make_ray(-5 * one, one + eps + 1, 0, one, -eps, 0, 0, smax));
    send_ray(make_ray(-5 * one, -one - eps, 0, one, 0, eps + 1, 0, smax));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, smax));
    send_ray(make_ray(0, 0, 0, smin, smin, smin, smin, smax));
    send_ray(make_ray(smax, 0, 0, smin, 0, 0, 0, smax));
    send_ray(make_ray(smin, smin, smin, smax, smax, smax, smin, smax));
    send_ray(make_ray(smax, smax, smax, 1, 1, 1, smin, smax));
    send_ray(make_ray(-5 * one, 0, 0, one, 0, 0, 10 * one, smax));
    send_ray(make_ray(-5 * one, 0, 0, one, 0, 0, 0, 2 * one));
    send_ray(make_ray(-5 * one, 0, 0, one, 0, 0, 3 * one, one));
    send_ray(make_ray(-5 * one, 0, 0, eps + 1, 0, 0, 0, smax));
    send_ray(make_ray(-one, 0, 0, one, 0, 0, -one, smax));
    send_ray(make_ray(2 * one, 2 * one, 2 * one, -one, -one, -one, 0, smax));
    send_ray(make_ray('1, '1, '1, '1, '1, '1, '1, '1));
    send_ray(make_ray(0, 0, 0, one, 0, 0, smax, smax));
    random_rays(200);

    // Random small box, with one full pause of the sender midway.
    set_box(rnd_span(34), rnd_span(34), rnd_span(34), rnd_span(34) + (one <<< 4),
            rnd_span(34) + (one <<< 4), rnd_span(34) + (one <<< 4));
    random_rays(100);
    drain();
    random_rays(120);

    // Widest possible box.
    set_box(smin, smin, smin, smax, smax, smax);
    random_rays(200);

    // Inverted box.
    set_box(one, 2 * one, 3 * one, -one, 0, one);
    random_rays(150);

    // Random large box; no idling at the very end.
    set_box(rnd_span(44) - (one <<< 12), rnd_span(44) - (one <<< 12), rnd_span(44) - (one <<< 12),
            rnd_span(44) + (one <<< 12), rnd_span(44) + (one <<< 12), rnd_span(44) + (one <<< 12));
    random_rays(200);
    quiet = 1'b1;
    random_rays(150);

    drain();
    if (sb.errors == 0) begin
      $display("ray_box_slab_intersection regression: pass");
    end else begin
      $display("ray_box_slab_intersection regression: fail");
    end
    $finish;
  end
endmodule
